>>> design/rpc_pkg.sv
// Package holding the shared types and constants of the resource price curve block.
package rpc_pkg;

   localparam int unsigned DIV_STAGES = 128;
   localparam int unsigned NUM_WIDTH  = 128;
   localparam int unsigned DEN_WIDTH  = 65;
   localparam int unsigned ADDR_WIDTH = 5;

   localparam logic [1:0] REG_NUM_COEFF  = 2'd0;
   localparam logic [1:0] REG_DEN_OFFSET = 2'd1;
   localparam logic [1:0] REG_SHIFT      = 2'd2;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_REGEN    = 3'd1;
   localparam logic [2:0] ERR_ZERO_DIV = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_MOST_NEG = 3'd4;

   typedef struct packed {
      logic [2:0] err;
      logic       zero;
      logic       neg;
   } meta_type;

endpackage

>>> design/rpc_if.sv
// Handshake interfaces for the request and response channels.
interface rpc_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] pool_level;
   logic signed [63:0] usage_count;
   logic signed [63:0] regen_rate;
   modport source (output valid, pool_level, usage_count, regen_rate, input ready);
   modport sink   (input valid, pool_level, usage_count, regen_rate, output ready);
endinterface

interface rpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] cost;
   logic [2:0]         error_code;
   modport source (output valid, cost, error_code, input ready);
   modport sink   (input valid, cost, error_code, output ready);
endinterface

>>> design/rpc_divider.sv
// Pipelined restoring divider that produces one quotient bit per stage.
module rpc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [rpc_pkg::NUM_WIDTH-1:0]     in_num,
   input  logic [rpc_pkg::DEN_WIDTH-1:0]     in_den,
   input  rpc_pkg::meta_type                 in_meta,
   output logic                              out_valid,
   output logic [rpc_pkg::NUM_WIDTH-1:0]     out_quot,
   output rpc_pkg::meta_type                 out_meta
);
   import rpc_pkg::*;

   logic                 valid_ff [DIV_STAGES];
   logic [DEN_WIDTH-1:0] rem_ff   [DIV_STAGES];
   logic [NUM_WIDTH-1:0] quot_ff  [DIV_STAGES];
   logic [DEN_WIDTH-1:0] den_ff   [DIV_STAGES];
   meta_type             meta_ff  [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic                 valid_src;
      logic [DEN_WIDTH-1:0] rem_src;
      logic [NUM_WIDTH-1:0] quot_src;
      logic [DEN_WIDTH-1:0] den_src;
      meta_type             meta_src;
      logic [DEN_WIDTH:0]   trial;
      logic [DEN_WIDTH:0]   diff;
      logic                 take;
      logic [DEN_WIDTH-1:0] rem_in;
      logic [NUM_WIDTH-1:0] quot_in;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign quot_src  = in_num;
         assign den_src   = in_den;
         assign meta_src  = in_meta;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign quot_src  = quot_ff[i-1];
         assign den_src   = den_ff[i-1];
         assign meta_src  = meta_ff[i-1];
      end

      always_comb begin
         trial   = {rem_src, quot_src[NUM_WIDTH-1]};
         diff    = trial - {1'b0, den_src};
         take    = trial >= {1'b0, den_src};
         rem_in  = take ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         quot_in = {quot_src[NUM_WIDTH-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= quot_in;
            den_ff[i]  <= den_src;
            meta_ff[i] <= meta_src;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quot  = quot_ff[DIV_STAGES-1];
   assign out_meta  = meta_ff[DIV_STAGES-1];
endmodule

>>> design/resource_price_curve_core.sv
// Top level of the resource price curve block with its register port.
// A request word runs through stages 1 to 5, the divider and the output stage.
// Throughput: one word per cycle unless the output stalls; the divider has 128 stages.
// The whole pipeline advances together and holds while the output word waits.
// Reset is synchronous and clears every valid bit and the registers to their defaults.
module resource_price_curve_core (
   input  logic                             clock,
   input  logic                             reset,
   rpc_req_if.sink                          req_word,
   rpc_rsp_if.source                        rsp_word,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rpc_pkg::ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [63:0]                      csr_pwdata,
   output logic [63:0]                      csr_prdata,
   output logic                             csr_pready
);
   import rpc_pkg::*;

   logic [63:0] coeff_ff, offset_ff;
   logic [6:0]  shift_ff;
   logic        cfg_write;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= '0;
         offset_ff <= 64'd1;
         shift_ff  <= '0;
      end else if (cfg_write) begin
         unique case (csr_paddr[4:3])
            REG_NUM_COEFF:  coeff_ff  <= csr_pwdata;
            REG_DEN_OFFSET: offset_ff <= csr_pwdata;
            REG_SHIFT:      shift_ff  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_NUM_COEFF:  csr_prdata = coeff_ff;
         REG_DEN_OFFSET: csr_prdata = offset_ff;
         REG_SHIFT:      csr_prdata = {57'd0, shift_ff};
         default:        csr_prdata = '0;
      endcase
   end

   logic adv;
   logic out_valid_ff;
   assign adv            = !out_valid_ff || rsp_word.ready;
   assign req_word.ready = adv;

   // Stage 1: checks, magnitude, divisor and partial products of regen and coefficient.
   logic                 s1_valid_ff;
   logic [63:0]          s1_pp_ff [4];
   logic [63:0]          s1_mag_ff;
   logic [DEN_WIDTH-1:0] s1_den_ff;
   meta_type             s1_meta_ff;
   logic [63:0]          s1_pp_in [4];
   logic [63:0]          s1_mag_in;
   logic [DEN_WIDTH-1:0] s1_den_in;
   meta_type             s1_meta_in;
   logic [63:0]          pool_u, count_u, regen_u;

   always_comb begin
      pool_u  = req_word.pool_level;
      count_u = req_word.usage_count;
      regen_u = req_word.regen_rate;
      s1_meta_in.neg  = count_u[63];
      s1_meta_in.zero = count_u == '0;
      priority if (regen_u[63] || regen_u == '0) begin
         s1_meta_in.err = ERR_REGEN;
      end else if (count_u == '0) begin
         s1_meta_in.err = ERR_OK;
      end else if (count_u == {1'b1, 63'd0}) begin
         s1_meta_in.err = ERR_MOST_NEG;
      end else begin
         s1_meta_in.err = ERR_OK;
      end
      s1_mag_in   = count_u[63] ? (64'd0 - count_u) : count_u;
      s1_den_in   = {1'b0, offset_ff} + (pool_u[63] ? 65'd0 : {1'b0, pool_u});
      s1_pp_in[0] = regen_u[31:0]  * coeff_ff[31:0];
      s1_pp_in[1] = regen_u[31:0]  * coeff_ff[63:32];
      s1_pp_in[2] = regen_u[63:32] * coeff_ff[31:0];
      s1_pp_in[3] = regen_u[63:32] * coeff_ff[63:32];
   end

   // Stage 2: full product.
   logic                 s2_valid_ff;
   logic [127:0]         s2_prod_ff, s2_prod_in;
   logic [63:0]          s2_mag_ff;
   logic [DEN_WIDTH-1:0] s2_den_ff;
   meta_type             s2_meta_ff;

   always_comb begin
      s2_prod_in = {64'd0, s1_pp_ff[0]} + ({64'd0, s1_pp_ff[1]} << 32)
                 + ({64'd0, s1_pp_ff[2]} << 32) + ({64'd0, s1_pp_ff[3]} << 64);
   end

   // Stage 3: shift and increment.
   logic                 s3_valid_ff;
   logic [127:0]         s3_num_ff, s3_num_in;
   logic [63:0]          s3_mag_ff;
   logic [DEN_WIDTH-1:0] s3_den_ff;
   meta_type             s3_meta_ff;

   assign s3_num_in = (s2_prod_ff >> shift_ff) + 128'd1;

   // Stage 4: partial products of numerator and magnitude, kept below bit 128.
   logic                 s4_valid_ff;
   logic [63:0]          s4_pp_ff [7];
   logic [63:0]          s4_pp_in [7];
   logic [DEN_WIDTH-1:0] s4_den_ff;
   meta_type             s4_meta_ff;

   always_comb begin
      s4_pp_in[0] = s3_num_ff[31:0]   * s3_mag_ff[31:0];
      s4_pp_in[1] = s3_num_ff[31:0]   * s3_mag_ff[63:32];
      s4_pp_in[2] = s3_num_ff[63:32]  * s3_mag_ff[31:0];
      s4_pp_in[3] = s3_num_ff[63:32]  * s3_mag_ff[63:32];
      s4_pp_in[4] = s3_num_ff[95:64]  * s3_mag_ff[31:0];
      s4_pp_in[5] = s3_num_ff[95:64]  * s3_mag_ff[63:32];
      s4_pp_in[6] = s3_num_ff[127:96] * s3_mag_ff[31:0];
   end

   // Stage 5: wrapped dividend and the zero divisor check.
   logic                 s5_valid_ff;
   logic [127:0]         s5_num_ff, s5_num_in;
   logic [DEN_WIDTH-1:0] s5_den_ff;
   meta_type             s5_meta_ff, s5_meta_in;

   always_comb begin
      s5_num_in = {64'd0, s4_pp_ff[0]}
                + ({64'd0, s4_pp_ff[1]} << 32) + ({64'd0, s4_pp_ff[2]} << 32)
                + ({64'd0, s4_pp_ff[3]} << 64) + ({64'd0, s4_pp_ff[4]} << 64)
                + ({64'd0, s4_pp_ff[5]} << 96) + ({64'd0, s4_pp_ff[6]} << 96);
      s5_meta_in = s4_meta_ff;
      if (s4_meta_ff.err == ERR_OK && !s4_meta_ff.zero && s4_den_ff == '0) begin
         s5_meta_in.err = ERR_ZERO_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_word.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pp_ff   <= s1_pp_in;
         s1_mag_ff  <= s1_mag_in;
         s1_den_ff  <= s1_den_in;
         s1_meta_ff <= s1_meta_in;
         s2_prod_ff <= s2_prod_in;
         s2_mag_ff  <= s1_mag_ff;
         s2_den_ff  <= s1_den_ff;
         s2_meta_ff <= s1_meta_ff;
         s3_num_ff  <= s3_num_in;
         s3_mag_ff  <= s2_mag_ff;
         s3_den_ff  <= s2_den_ff;
         s3_meta_ff <= s2_meta_ff;
         s4_pp_ff   <= s4_pp_in;
         s4_den_ff  <= s3_den_ff;
         s4_meta_ff <= s3_meta_ff;
         s5_num_ff  <= s5_num_in;
         s5_den_ff  <= s4_den_ff;
         s5_meta_ff <= s5_meta_in;
      end
   end

   logic         div_valid;
   logic [127:0] div_quot;
   meta_type     div_meta;

   rpc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .in_meta   (s5_meta_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_meta  (div_meta)
   );

   // Output stage: overflow check, increment and sign.
   logic [63:0] cost_ff, cost_in, plus_one;
   logic [2:0]  err_ff, err_in;

   always_comb begin
      plus_one = div_quot[63:0] + 64'd1;
      priority if (div_meta.err != ERR_OK) begin
         err_in  = div_meta.err;
         cost_in = '0;
      end else if (div_meta.zero) begin
         err_in  = ERR_OK;
         cost_in = '0;
      end else if (div_quot[127:64] != '0 || div_quot[63:0] >= 64'h7FFF_FFFF_FFFF_FFFF) begin
         err_in  = ERR_OVERFLOW;
         cost_in = '0;
      end else begin
         err_in  = ERR_OK;
         cost_in = div_meta.neg ? (64'd0 - plus_one) : plus_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cost_ff <= cost_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_word.valid      = out_valid_ff;
   assign rsp_word.cost       = cost_ff;
   assign rsp_word.error_code = err_ff;
endmodule

>>> design/rpc_checker.sv
// Port-level checker for the resource price curve block and its bind statement.
module rpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [63:0] rsp_cost,
   input logic [2:0]        rsp_error_code
);
   import rpc_pkg::*;

   a_err_zero_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> rsp_cost == '0)
      else $error("Error word carries a non-zero cost.");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_MOST_NEG)
      else $error("Error code out of range.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response word valid straight after reset.");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request side stalled while the output is empty.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cost))
      else $error("Stalled response word changed.");
endmodule

bind resource_price_curve_core rpc_checker u_rpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_word.ready),
   .rsp_valid      (rsp_word.valid),
   .rsp_ready      (rsp_word.ready),
   .rsp_cost       (rsp_word.cost),
   .rsp_error_code (rsp_word.error_code)
);
